>>> rtl/stli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted table linear interpolator.
// ----------------------------------------------------------------------------
package stli_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ANG_W       = 16;
	localparam int COF_W       = 16;
	localparam int ENT_W       = ANG_W + COF_W;
	localparam int DIFF_W      = ANG_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int STEP_W      = $clog2(PROD_W);

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_EXACT    = 3'd0,
		ST_INTERP   = 3'd1,
		ST_CLAMP_LO = 3'd2,
		ST_CLAMP_HI = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_STORED   = 3'd5,
		ST_FULL     = 3'd6,
		ST_CLEARED  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_RDATA,
		SRC_INTERP
	} res_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_WR,
		S_Q_RD,
		S_Q_CHK,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     load;
		logic     clr_cnt;
		logic     inc_cnt;
		logic     idx_from_cnt;
		logic     idx_clr;
		logic     idx_inc;
		logic     idx_dec;
		logic     rd_prev;
		logic     ram_we;
		logic     wr_new;
		logic     save_prev;
		logic     setup;
		logic     mul;
		logic     div_step;
		logic     finish;
		res_src_t src;
		status_t  st;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       cnt_zero;
		logic       full;
		logic       rd_eq;
		logic       rd_gt;
		logic       idx_zero;
		logic       idx_one;
		logic       idx_last;
		logic       div_last;
	} sts_t;

endpackage

>>> rtl/sorted_table_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator
// Sorted point table with exact-match lookup and linear interpolation.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, angle and coeff while busy is low; the
// item is taken at that clock edge and busy stays high until it is finished.
// Exactly one result comes back per item, on result_coeff and status, for a
// single cycle marked by done. The receiver cannot stall, so the result must
// be captured on that cycle. A clear, an unused request code, an insert into
// a full table or a query of an empty table finishes straight from decode. An
// insert compares entries from the end of the table through the single-port
// table memory, moving every larger one up, and then writes the new point. A
// query reads entries from the start; an exact match or a clamp finishes at
// the entry that settles it, and an interpolation adds a multiply, the
// bit-serial divider and a saturating finish. The slowest item is an
// interpolation against the last of 64 entries.
// Clear resets only the entry count; stale table contents are never read.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic signed [stli_pkg::ANG_W-1:0] angle,
	input  logic signed [stli_pkg::COF_W-1:0] coeff,
	output logic                              done,
	output logic signed [stli_pkg::COF_W-1:0] result_coeff,
	output logic [2:0]                        status
);

	// The controller sequences each item; the datapath holds the table and
	// does the arithmetic.
	stli_pkg::cmd_t cmd;
	stli_pkg::sts_t sts;

	stli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	stli_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req_type),
		.angle        (angle),
		.coeff        (coeff),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.result_coeff (result_coeff),
		.status       (status)
	);

endmodule

>>> rtl/stli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module stli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/stli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_ctrl
// Request sequencer: walks the table for inserts and queries and drives the
// divider through its steps.
// ----------------------------------------------------------------------------
module stli_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  stli_pkg::sts_t  sts,
	output stli_pkg::cmd_t  cmd
);

	stli_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stli_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != stli_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = stli_pkg::SRC_ZERO;
		cmd.st  = stli_pkg::ST_EMPTY;
		case (state_q)
			stli_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = stli_pkg::S_DECODE;
				end
			end
			stli_pkg::S_DECODE: begin
				case (sts.req)
					stli_pkg::REQ_CLEAR: begin
						cmd.clr_cnt = 1'b1;
						cmd.finish  = 1'b1;
						cmd.st      = stli_pkg::ST_CLEARED;
						state_d     = stli_pkg::S_IDLE;
					end
					stli_pkg::REQ_INSERT: begin
						if (sts.full) begin
							cmd.finish = 1'b1;
							cmd.st     = stli_pkg::ST_FULL;
							state_d    = stli_pkg::S_IDLE;
						end else begin
							cmd.idx_from_cnt = 1'b1;
							state_d = sts.cnt_zero ? stli_pkg::S_INS_WR : stli_pkg::S_INS_RD;
						end
					end
					stli_pkg::REQ_QUERY: begin
						if (sts.cnt_zero) begin
							cmd.finish = 1'b1;
							cmd.st     = stli_pkg::ST_EMPTY;
							state_d    = stli_pkg::S_IDLE;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = stli_pkg::S_Q_RD;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.st     = stli_pkg::ST_EMPTY;
						state_d    = stli_pkg::S_IDLE;
					end
				endcase
			end
			stli_pkg::S_INS_RD: begin
				cmd.rd_prev = 1'b1;
				state_d     = stli_pkg::S_INS_CHK;
			end
			stli_pkg::S_INS_CHK: begin
				if (sts.rd_gt) begin
					cmd.ram_we  = 1'b1;
					cmd.idx_dec = 1'b1;
					state_d = sts.idx_one ? stli_pkg::S_INS_WR : stli_pkg::S_INS_RD;
				end else begin
					state_d = stli_pkg::S_INS_WR;
				end
			end
			stli_pkg::S_INS_WR: begin
				cmd.ram_we  = 1'b1;
				cmd.wr_new  = 1'b1;
				cmd.inc_cnt = 1'b1;
				cmd.finish  = 1'b1;
				cmd.st      = stli_pkg::ST_STORED;
				state_d     = stli_pkg::S_IDLE;
			end
			stli_pkg::S_Q_RD: begin
				state_d = stli_pkg::S_Q_CHK;
			end
			stli_pkg::S_Q_CHK: begin
				if (sts.rd_eq) begin
					cmd.finish = 1'b1;
					cmd.src    = stli_pkg::SRC_RDATA;
					cmd.st     = stli_pkg::ST_EXACT;
					state_d    = stli_pkg::S_IDLE;
				end else if (sts.rd_gt) begin
					if (sts.idx_zero) begin
						cmd.finish = 1'b1;
						cmd.src    = stli_pkg::SRC_RDATA;
						cmd.st     = stli_pkg::ST_CLAMP_LO;
						state_d    = stli_pkg::S_IDLE;
					end else begin
						cmd.setup = 1'b1;
						state_d   = stli_pkg::S_MUL;
					end
				end else if (sts.idx_last) begin
					cmd.finish = 1'b1;
					cmd.src    = stli_pkg::SRC_RDATA;
					cmd.st     = stli_pkg::ST_CLAMP_HI;
					state_d    = stli_pkg::S_IDLE;
				end else begin
					cmd.save_prev = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = stli_pkg::S_Q_RD;
				end
			end
			stli_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = stli_pkg::S_DIV;
			end
			stli_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = stli_pkg::S_FIN;
				end
			end
			stli_pkg::S_FIN: begin
				cmd.finish = 1'b1;
				cmd.src    = stli_pkg::SRC_INTERP;
				cmd.st     = stli_pkg::ST_INTERP;
				state_d    = stli_pkg::S_IDLE;
			end
			default: begin
				state_d = stli_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/stli_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_dp
// Datapath: table memory, entry count, scan index, interpolation multiply,
// serial divider and result register.
// ----------------------------------------------------------------------------
module stli_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          req_type,
	input  logic signed [stli_pkg::ANG_W-1:0]   angle,
	input  logic signed [stli_pkg::COF_W-1:0]   coeff,
	input  stli_pkg::cmd_t                      cmd,
	output stli_pkg::sts_t                      sts,
	output logic                                done,
	output logic signed [stli_pkg::COF_W-1:0]   result_coeff,
	output logic [2:0]                          status
);

	logic [1:0]                               req_q;
	logic signed [stli_pkg::ANG_W-1:0]        ang_q;
	logic signed [stli_pkg::COF_W-1:0]        cof_q;
	logic [stli_pkg::CNT_W-1:0]               cnt_q;
	logic [stli_pkg::CNT_W-1:0]               idx_q;
	logic signed [stli_pkg::ANG_W-1:0]        prev_ang_q;
	logic signed [stli_pkg::COF_W-1:0]        prev_cof_q;
	logic signed [stli_pkg::DIFF_W-1:0]       da_q, dc_q;
	logic [stli_pkg::DIFF_W-1:0]              den_q;
	logic signed [stli_pkg::COF_W-1:0]        lc_q;
	logic                                     neg_q;
	logic [stli_pkg::PROD_W-1:0]              quo_q;
	logic [stli_pkg::DIFF_W-1:0]              rem_q;
	logic [stli_pkg::STEP_W-1:0]              step_q;
	logic                                     done_q;
	logic signed [stli_pkg::COF_W-1:0]        res_q;
	logic [2:0]                               status_q;

	logic [stli_pkg::ENT_W-1:0]               ram_rdata, ram_wdata;
	logic [stli_pkg::ADDR_W-1:0]              ram_addr;
	logic [stli_pkg::CNT_W-1:0]               idx_m1;
	logic signed [stli_pkg::ANG_W-1:0]        rd_ang;
	logic signed [stli_pkg::COF_W-1:0]        rd_cof;
	logic signed [stli_pkg::PROD_W-1:0]       prod;
	logic [stli_pkg::DIFF_W:0]                shifted;
	logic [stli_pkg::DIFF_W+1:0]              trial;
	logic signed [stli_pkg::PROD_W:0]         quo_s;
	logic signed [stli_pkg::PROD_W+1:0]       sum;
	logic signed [stli_pkg::COF_W-1:0]        sat;
	logic signed [stli_pkg::COF_W-1:0]        res_d;

	assign idx_m1   = idx_q - 1'b1;
	assign ram_addr = cmd.rd_prev ? idx_m1[stli_pkg::ADDR_W-1:0] : idx_q[stli_pkg::ADDR_W-1:0];
	assign ram_wdata = cmd.wr_new ? {ang_q, cof_q} : ram_rdata;
	assign rd_ang   = ram_rdata[stli_pkg::ENT_W-1:stli_pkg::COF_W];
	assign rd_cof   = ram_rdata[stli_pkg::COF_W-1:0];

	stli_ram #(
		.WIDTH(stli_pkg::ENT_W),
		.DEPTH(stli_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign sts.req      = req_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.full     = (cnt_q == stli_pkg::CNT_W'(stli_pkg::TABLE_DEPTH));
	assign sts.rd_eq    = (rd_ang == ang_q);
	assign sts.rd_gt    = (rd_ang > ang_q);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.idx_one  = (idx_q == stli_pkg::CNT_W'(1));
	assign sts.idx_last = ((idx_q + 1'b1) == cnt_q);
	assign sts.div_last = (step_q == stli_pkg::STEP_W'(stli_pkg::PROD_W - 1));

	// Restoring divide: one quotient bit per cycle.
	assign prod    = da_q * dc_q;
	assign shifted = {rem_q, quo_q[stli_pkg::PROD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign quo_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum     = (stli_pkg::PROD_W+2)'(lc_q) + (stli_pkg::PROD_W+2)'(quo_s);

	always_comb begin
		if (sum > (stli_pkg::PROD_W+2)'(32767)) begin
			sat = 16'sh7fff;
		end else if (sum < -(stli_pkg::PROD_W+2)'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = sum[stli_pkg::COF_W-1:0];
		end
		case (cmd.src)
			stli_pkg::SRC_RDATA:  res_d = rd_cof;
			stli_pkg::SRC_INTERP: res_d = sat;
			default:              res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.inc_cnt) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			ang_q <= angle;
			cof_q <= coeff;
		end
		if (cmd.idx_from_cnt) begin
			idx_q <= cnt_q;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end
		if (cmd.save_prev) begin
			prev_ang_q <= rd_ang;
			prev_cof_q <= rd_cof;
		end
		if (cmd.setup) begin
			da_q  <= stli_pkg::DIFF_W'(ang_q) - stli_pkg::DIFF_W'(prev_ang_q);
			dc_q  <= stli_pkg::DIFF_W'(rd_cof) - stli_pkg::DIFF_W'(prev_cof_q);
			den_q <= stli_pkg::DIFF_W'(rd_ang) - stli_pkg::DIFF_W'(prev_ang_q);
			lc_q  <= prev_cof_q;
		end
		if (cmd.mul) begin
			neg_q  <= prod[stli_pkg::PROD_W-1];
			quo_q  <= prod[stli_pkg::PROD_W-1] ? stli_pkg::PROD_W'(-prod)
			                                    : stli_pkg::PROD_W'(prod);
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
			if (!trial[stli_pkg::DIFF_W+1]) begin
				rem_q <= trial[stli_pkg::DIFF_W-1:0];
				quo_q <= {quo_q[stli_pkg::PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[stli_pkg::DIFF_W-1:0];
				quo_q <= {quo_q[stli_pkg::PROD_W-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			res_q    <= res_d;
			status_q <= cmd.st;
		end
	end

	assign done         = done_q;
	assign result_coeff = res_q;
	assign status       = status_q;

endmodule

>>> rtl/stli_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_checker
// Port-level checks on the item handshake and result strobe.
// ----------------------------------------------------------------------------
module stli_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic signed [15:0] result_coeff,
	input logic [2:0]        status
);

	// Results are single-cycle strobes and never back to back.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// Every item finishes with its result on the cycle busy drops.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("busy dropped without a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == stli_pkg::ST_EMPTY || status == stli_pkg::ST_STORED ||
			status == stli_pkg::ST_FULL || status == stli_pkg::ST_CLEARED))
		|-> (result_coeff == 16'sd0))
		else $error("non-query result carries a coefficient");

endmodule

bind sorted_table_linear_interpolator stli_checker u_stli_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_coeff (result_coeff),
	.status       (status)
);
